[design/ssrp_pkg.sv]
// ----------------------------------------------------------------------------
// ssrp_pkg
// Shared types and constants for the shadow stack read memory size profiler.
// ----------------------------------------------------------------------------
package ssrp_pkg;

    // sizing
    localparam int STACK_DEPTH = 256;
    localparam int ADDR_BITS   = 16;
    localparam int MAX_ACCESS  = 8;

    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int CNT_W = $clog2(MAX_ACCESS + 1);

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [SP_W-1:0]      t_sp;
    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [CNT_W-1:0]     t_cnt;

    // action codes
    localparam logic [1:0] ACT_CALL  = 2'd0;
    localparam logic [1:0] ACT_RET   = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_WRITE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] routine_id;
        logic [15:0] address;
        logic [3:0]  length;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic               frame_valid;
        logic [15:0]        popped_routine;
        logic [31:0]        popped_start;
        logic signed [31:0] popped_rms;
    } t_res;

    // one shadow stack entry
    typedef struct packed {
        logic [15:0] routine;
        logic [31:0] call_time;
        logic [31:0] rms;
    } t_frame;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CALL,
        S_RET_RD,
        S_RET_PAR,
        S_RET_WR,
        S_BYTE_RD,
        S_BYTE_CHK,
        S_TOP_WR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DEC_WR,
        S_DONE
    } t_state;

endpackage

[design/ssrp_ram.sv]
// ----------------------------------------------------------------------------
// ssrp_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ssrp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/shadow_stack_rms_profiler.sv]
// ----------------------------------------------------------------------------
// shadow_stack_rms_profiler
// Shadow stack profiler: per-routine read memory size from a byte stamp store.
// ----------------------------------------------------------------------------
// Steps: a call pushes a frame; a return pops the top frame (none when empty)
//   and adds its count to the caller's; accesses go byte by byte, reads scan frames.
// Handshake: one word at a time; busy stays high through the result strobe,
//   the next word is taken the cycle after. Frame scans set the read cost.
// Reset: synchronous; afterwards all 2^ADDR_BITS (65536) byte stamp entries are
//   swept to zero with busy high. The receiver cannot stall.
// ----------------------------------------------------------------------------
module shadow_stack_rms_profiler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ssrp_pkg::t_cmd i_cmd,
    output logic          o_res_valid,
    output ssrp_pkg::t_res o_res
);

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    ssrp_pkg::t_state r_state, n_state;
    ssrp_pkg::t_sp    r_top, n_top;
    logic [31:0]      r_calls, n_calls;
    ssrp_pkg::t_addr  r_addr, n_addr;
    ssrp_pkg::t_cnt   r_left, n_left;
    logic             r_is_wr, n_is_wr;
    logic [31:0]      r_stamp, n_stamp;
    ssrp_pkg::t_sp    r_k, n_k;
    logic [15:0]      r_rid, n_rid;
    ssrp_pkg::t_res   r_res, n_res;

    // memory ports
    logic             fr_we;
    ssrp_pkg::t_idx   fr_waddr, fr_raddr;
    ssrp_pkg::t_frame fr_wdata, fr_rdata;
    logic             bs_we;
    ssrp_pkg::t_addr  bs_waddr, bs_raddr;
    logic [31:0]      bs_wdata, bs_rdata;

    ssrp_pkg::t_idx  top_idx;
    ssrp_pkg::t_idx  k_idx;
    logic [31:0]     calls_inc;
    logic            hit;
    logic            last_byte;

    assign top_idx   = ssrp_pkg::t_idx'(r_top - 1'b1);
    assign k_idx     = ssrp_pkg::t_idx'(r_k);
    assign calls_inc = (r_calls == CNT_MAX) ? r_calls : r_calls + 32'd1;
    assign hit       = (r_top != '0) && (bs_rdata < fr_rdata.call_time);
    assign last_byte = (r_left == '0);

    // memories
    ssrp_ram #(.WIDTH($bits(ssrp_pkg::t_frame)), .DEPTH(ssrp_pkg::STACK_DEPTH)) u_frame_ram (
        .i_clk(i_clk), .i_we(fr_we), .i_waddr(fr_waddr), .i_wdata(fr_wdata),
        .i_raddr(fr_raddr), .o_rdata(fr_rdata)
    );
    ssrp_ram #(.WIDTH(32), .DEPTH(2 ** ssrp_pkg::ADDR_BITS)) u_stamp_ram (
        .i_clk(i_clk), .i_we(bs_we), .i_waddr(bs_waddr), .i_wdata(bs_wdata),
        .i_raddr(bs_raddr), .o_rdata(bs_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ssrp_pkg::S_CLEAR: begin
                if (r_addr == '1) n_state = ssrp_pkg::S_IDLE;
            end
            ssrp_pkg::S_IDLE: begin
                if (start) begin
                    case (i_cmd.action)
                        ssrp_pkg::ACT_CALL: n_state = ssrp_pkg::S_CALL;
                        ssrp_pkg::ACT_RET: begin
                            n_state = (r_top == '0) ? ssrp_pkg::S_DONE
                                                    : ssrp_pkg::S_RET_RD;
                        end
                        default: begin
                            n_state = (i_cmd.length == '0) ? ssrp_pkg::S_DONE
                                                           : ssrp_pkg::S_BYTE_RD;
                        end
                    endcase
                end
            end
            ssrp_pkg::S_CALL:    n_state = ssrp_pkg::S_DONE;
            ssrp_pkg::S_RET_RD:  n_state = ssrp_pkg::S_RET_PAR;
            ssrp_pkg::S_RET_PAR: begin
                n_state = (top_idx != '0) ? ssrp_pkg::S_RET_WR : ssrp_pkg::S_DONE;
            end
            ssrp_pkg::S_RET_WR:  n_state = ssrp_pkg::S_DONE;
            ssrp_pkg::S_BYTE_RD: begin
                if (!r_is_wr) begin
                    n_state = ssrp_pkg::S_BYTE_CHK;
                end else if (r_left == ssrp_pkg::t_cnt'(1)) begin
                    n_state = ssrp_pkg::S_DONE;
                end
            end
            ssrp_pkg::S_BYTE_CHK: begin
                if (hit) begin
                    n_state = ssrp_pkg::S_TOP_WR;
                end else begin
                    n_state = (r_left == ssrp_pkg::t_cnt'(1)) ? ssrp_pkg::S_DONE
                                                              : ssrp_pkg::S_BYTE_RD;
                end
            end
            ssrp_pkg::S_TOP_WR: begin
                if (r_stamp != '0) begin
                    n_state = ssrp_pkg::S_SCAN_RD;
                end else begin
                    n_state = last_byte ? ssrp_pkg::S_DONE : ssrp_pkg::S_BYTE_RD;
                end
            end
            ssrp_pkg::S_SCAN_RD: n_state = ssrp_pkg::S_SCAN_CHK;
            ssrp_pkg::S_SCAN_CHK: begin
                if (fr_rdata.call_time <= r_stamp) begin
                    n_state = ssrp_pkg::S_DEC_WR;
                end else if (r_k != '0) begin
                    n_state = ssrp_pkg::S_SCAN_RD;
                end else begin
                    n_state = last_byte ? ssrp_pkg::S_DONE : ssrp_pkg::S_BYTE_RD;
                end
            end
            ssrp_pkg::S_DEC_WR: begin
                n_state = last_byte ? ssrp_pkg::S_DONE : ssrp_pkg::S_BYTE_RD;
            end
            ssrp_pkg::S_DONE: n_state = ssrp_pkg::S_IDLE;
            default:          n_state = ssrp_pkg::S_IDLE;
        endcase
    end

    // datapath register updates
    always_comb begin
        n_top   = r_top;
        n_calls = r_calls;
        n_addr  = r_addr;
        n_left  = r_left;
        n_is_wr = r_is_wr;
        n_stamp = r_stamp;
        n_k     = r_k;
        n_rid   = r_rid;
        n_res   = r_res;
        case (r_state)
            ssrp_pkg::S_CLEAR: begin
                n_addr = r_addr + 1'b1;
            end
            ssrp_pkg::S_IDLE: begin
                if (start) begin
                    n_res   = '0;
                    n_rid   = i_cmd.routine_id;
                    n_addr  = ssrp_pkg::t_addr'(i_cmd.address);
                    n_is_wr = (i_cmd.action == ssrp_pkg::ACT_WRITE);
                    if (int'(i_cmd.length) > ssrp_pkg::MAX_ACCESS) begin
                        n_left = ssrp_pkg::t_cnt'(ssrp_pkg::MAX_ACCESS);
                    end else begin
                        n_left = ssrp_pkg::t_cnt'(i_cmd.length);
                    end
                    if (i_cmd.action == ssrp_pkg::ACT_RET && r_top == '0) begin
                        n_res.status = ssrp_pkg::ST_EMPTY;
                    end
                end
            end
            ssrp_pkg::S_CALL: begin
                if (r_top == ssrp_pkg::t_sp'(ssrp_pkg::STACK_DEPTH)) begin
                    n_res.status = ssrp_pkg::ST_FULL;
                end else begin
                    n_calls = calls_inc;
                    n_top   = r_top + 1'b1;
                end
            end
            ssrp_pkg::S_RET_PAR: begin
                n_res.frame_valid    = 1'b1;
                n_res.popped_routine = fr_rdata.routine;
                n_res.popped_start   = fr_rdata.call_time;
                n_res.popped_rms     = fr_rdata.rms;
                if (top_idx == '0) n_top = r_top - 1'b1;
            end
            ssrp_pkg::S_RET_WR: begin
                n_top = r_top - 1'b1;
            end
            ssrp_pkg::S_BYTE_RD: begin
                if (r_is_wr) begin
                    n_addr = r_addr + 1'b1;
                    n_left = r_left - 1'b1;
                end
            end
            ssrp_pkg::S_BYTE_CHK: begin
                n_stamp = bs_rdata;
                n_addr  = r_addr + 1'b1;
                n_left  = r_left - 1'b1;
            end
            ssrp_pkg::S_TOP_WR:  n_k = r_top;
            ssrp_pkg::S_SCAN_RD: n_k = r_k - 1'b1;
            default: ;
        endcase
    end

    // memory controls: frame updates rewrite the entry read the cycle before
    always_comb begin
        fr_we = 1'b0; fr_waddr = top_idx; fr_wdata = fr_rdata;
        fr_raddr = top_idx;
        bs_we = 1'b0; bs_waddr = r_addr; bs_wdata = r_calls;
        bs_raddr = r_addr;
        case (r_state)
            ssrp_pkg::S_CLEAR: begin
                bs_we    = 1'b1;
                bs_wdata = '0;
            end
            ssrp_pkg::S_CALL: begin
                if (r_top != ssrp_pkg::t_sp'(ssrp_pkg::STACK_DEPTH)) begin
                    fr_we              = 1'b1;
                    fr_waddr           = ssrp_pkg::t_idx'(r_top);
                    fr_wdata.routine   = r_rid;
                    fr_wdata.call_time = calls_inc;
                    fr_wdata.rms       = '0;
                end
            end
            ssrp_pkg::S_RET_PAR: begin
                fr_raddr = top_idx - 1'b1;
            end
            ssrp_pkg::S_RET_WR: begin
                fr_we        = 1'b1;
                fr_waddr     = top_idx - 1'b1;
                fr_wdata.rms = fr_rdata.rms + r_res.popped_rms;
            end
            ssrp_pkg::S_BYTE_RD: begin
                bs_we = r_is_wr;
            end
            ssrp_pkg::S_BYTE_CHK: begin
                bs_we = 1'b1;
            end
            ssrp_pkg::S_TOP_WR: begin
                fr_we        = 1'b1;
                fr_wdata.rms = fr_rdata.rms + 32'd1;
            end
            ssrp_pkg::S_SCAN_RD: begin
                fr_raddr = ssrp_pkg::t_idx'(r_k - 1'b1);
            end
            ssrp_pkg::S_SCAN_CHK: begin
                fr_raddr = k_idx;
            end
            ssrp_pkg::S_DEC_WR: begin
                fr_we        = 1'b1;
                fr_waddr     = k_idx;
                fr_wdata.rms = fr_rdata.rms - 32'd1;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssrp_pkg::S_CLEAR;
            r_top   <= '0;
            r_calls <= '0;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_calls <= n_calls;
            r_addr  <= n_addr;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_is_wr <= n_is_wr;
        r_stamp <= n_stamp;
        r_k     <= n_k;
        r_rid   <= n_rid;
        r_res   <= n_res;
    end

    assign busy        = (r_state != ssrp_pkg::S_IDLE);
    assign o_res_valid = (r_state == ssrp_pkg::S_DONE);
    assign o_res       = r_res;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted word");
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe longer than one cycle");
    a_frame_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.frame_valid |-> o_res.status == ssrp_pkg::ST_OK)
        else $error("popped frame with error status");
    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= ssrp_pkg::t_sp'(ssrp_pkg::STACK_DEPTH))
        else $error("stack pointer beyond depth");
`endif

endmodule
